[hdl/cds_pkg.sv]
// Package for the calendar date stepper: types, codes, widths and the
// month length function. It depends on nothing else.
package cds_pkg;

    // Width of the step count as given by the project.
    localparam int COUNT_BITS = 16;
    // Width of the day_count field on the input beat.
    localparam int COUNT_FIELD_W = 16;
    // Bits of the count actually used: the narrower of the two.
    localparam int CNT_W = (COUNT_BITS < COUNT_FIELD_W) ? COUNT_BITS : COUNT_FIELD_W;

    // Field widths.
    localparam int DAY_W   = 5;
    localparam int MONTH_W = 4;
    localparam int YEAR_W  = 16;
    localparam int ORDER_W = 2;

    // Calendar constants.
    localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
    localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
    localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;
    localparam logic [DAY_W-1:0]   DAY_FIRST = 5'd1;

    // Multiplicative inverse of 25 modulo 2^16: a year is a multiple of 25
    // exactly when year * inverse (mod 2^16) is no larger than 65535 / 25.
    localparam logic [YEAR_W-1:0] INV25      = 16'd23593;
    localparam logic [YEAR_W-1:0] DIV25_MAX  = 16'd2621;

    // Operation codes.
    typedef enum logic [1:0] {
        FN_LOAD = 2'd0,
        FN_FWD  = 2'd1,
        FN_BWD  = 2'd2,
        FN_CMP  = 2'd3
    } t_func;

    // Compare results.
    typedef enum logic [ORDER_W-1:0] {
        ORD_EARLIER = 2'd0,
        ORD_EQUAL   = 2'd1,
        ORD_LATER   = 2'd2
    } t_order;

    // Sequencer states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_PREP,
        S_LOAD,
        S_STEP,
        S_DONE
    } t_state;

    // Length of a month, given whether its year is a leap year.
    function automatic logic [DAY_W-1:0] month_length(
        input logic [MONTH_W-1:0] month,
        input logic               leap
    );
        logic [DAY_W-1:0] len;
        case (month) inside
            4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
            MONTH_FEB:               len = leap ? 5'd29 : 5'd28;
            default:                 len = 5'd31;
        endcase
        return len;
    endfunction

endpackage

[hdl/cds_if.sv]
// Handshake interfaces for the date stepper's input and result channels.
// Depends on cds_pkg for the field widths.
interface cds_in_if import cds_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic [1:0]             func;
    logic [COUNT_FIELD_W-1:0] day_count;
    logic [DAY_W-1:0]       in_day;
    logic [MONTH_W-1:0]     in_month;
    logic [YEAR_W-1:0]      in_year;

    modport source (output valid, func, day_count, in_day, in_month, in_year,
                    input ready);
    modport sink   (input valid, func, day_count, in_day, in_month, in_year,
                    output ready);
endinterface

interface cds_out_if import cds_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [DAY_W-1:0]     out_day;
    logic [MONTH_W-1:0]   out_month;
    logic [YEAR_W-1:0]    out_year;
    logic [ORDER_W-1:0]   order;

    modport source (output valid, out_day, out_month, out_year, order,
                    input ready);
    modport sink   (input valid, out_day, out_month, out_year, order,
                    output ready);
endinterface

[hdl/cds_leap_unit.sv]
// Leap year unit: registers whether the presented year is a leap year.
// Depends on cds_pkg.
module cds_leap_unit
    import cds_pkg::*;
(
    input  logic              i_clk,
    input  logic [YEAR_W-1:0] i_year,
    output logic              o_leap
);

    logic [YEAR_W-1:0] prod;
    logic              div25;
    logic              leap;
    logic              r_leap;

    // Divisibility by 25 through the modular inverse; by 4 and 16 from the
    // low bits. A century is a leap year only when it is a multiple of 400,
    // that is of 25 and of 16.
    assign prod  = i_year * INV25;
    assign div25 = (prod <= DIV25_MAX);
    assign leap  = (i_year[1:0] == 2'd0) && (!div25 || (i_year[3:0] == 4'd0));

    // The result is registered before it is used.
    always_ff @(posedge i_clk) begin
        r_leap <= leap;
    end

    assign o_leap = r_leap;

endmodule

[hdl/calendar_date_stepper.sv]
// Top level of the calendar date stepper: sequencer, date registers and
// result register. Depends on cds_pkg, cds_if and cds_leap_unit.
//
// The block holds one Gregorian date and handles one beat at a time. An
// accepted beat passes the preparation state; a load beat then passes the
// load state, a compare beat goes on to the result, and a forward or
// backward beat by n days passes the step state once per day, the single
// day stepper moving the date by one day per cycle. The input is ready again
// in the cycle after the result beat is taken. The leap year flag comes from
// a registered unit shared by load and stepping, hence the preparation state.
module calendar_date_stepper
    import cds_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    cds_in_if.sink    i_in,
    cds_out_if.source o_out
);

    t_state r_state, n_state;

    logic [DAY_W-1:0]   r_day,   n_day;
    logic [MONTH_W-1:0] r_month, n_month;
    logic [YEAR_W-1:0]  r_year,  n_year;
    logic [ORDER_W-1:0] r_order, n_order;
    logic [CNT_W-1:0]   r_cnt,   n_cnt;

    // Captured arguments of the beat in hand.
    t_func              r_func,  n_func;
    logic [DAY_W-1:0]   r_arg_day,   n_arg_day;
    logic [MONTH_W-1:0] r_arg_month, n_arg_month;
    logic [YEAR_W-1:0]  r_arg_year,  n_arg_year;

    logic [YEAR_W-1:0]  leap_year;
    logic               leap;
    logic [MONTH_W-1:0] load_month;
    logic [DAY_W-1:0]   load_len;
    logic [MONTH_W-1:0] prev_month;
    logic [DAY_W-1:0]   cur_len;

    // The leap unit sees the loaded year while preparing a load, and the
    // stored year otherwise.
    assign leap_year = (r_state == S_PREP && r_func == FN_LOAD) ? r_arg_year : r_year;

    cds_leap_unit u_leap (
        .i_clk  (i_clk),
        .i_year (leap_year),
        .o_leap (leap)
    );

    // Month and day limits used by load and by the day stepper.
    always_comb begin
        if (r_arg_month == 4'd0) begin
            load_month = MONTH_JAN;
        end else if (r_arg_month > MONTH_DEC) begin
            load_month = MONTH_DEC;
        end else begin
            load_month = r_arg_month;
        end
        load_len   = month_length(load_month, leap);
        prev_month = (r_month <= MONTH_JAN) ? MONTH_DEC : r_month - 4'd1;
        cur_len    = month_length(r_month, leap);
    end

    // Sequencer state and stored date registers, with reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_day   <= DAY_FIRST;
            r_month <= MONTH_JAN;
            r_year  <= '0;
        end else begin
            r_state <= n_state;
            r_day   <= n_day;
            r_month <= n_month;
            r_year  <= n_year;
        end
    end

    // Argument, count and result registers.
    always_ff @(posedge i_clk) begin
        r_func      <= n_func;
        r_arg_day   <= n_arg_day;
        r_arg_month <= n_arg_month;
        r_arg_year  <= n_arg_year;
        r_cnt       <= n_cnt;
        r_order     <= n_order;
    end

    // Next state and datapath.
    always_comb begin
        n_state     = r_state;
        n_day       = r_day;
        n_month     = r_month;
        n_year      = r_year;
        n_order     = r_order;
        n_cnt       = r_cnt;
        n_func      = r_func;
        n_arg_day   = r_arg_day;
        n_arg_month = r_arg_month;
        n_arg_year  = r_arg_year;

        unique case (r_state)
            S_IDLE: begin
                if (i_in.valid) begin
                    n_func      = t_func'(i_in.func);
                    n_arg_day   = i_in.in_day;
                    n_arg_month = i_in.in_month;
                    n_arg_year  = i_in.in_year;
                    n_cnt       = i_in.day_count[CNT_W-1:0];
                    n_order     = ORD_EARLIER;
                    n_state     = S_PREP;
                end
            end
            S_PREP: begin
                unique case (r_func)
                    FN_LOAD: n_state = S_LOAD;
                    FN_FWD, FN_BWD: begin
                        n_state = (r_cnt == '0) ? S_DONE : S_STEP;
                    end
                    FN_CMP: begin
                        // Year first, then month, then day.
                        if (r_year != r_arg_year) begin
                            n_order = (r_year > r_arg_year) ? ORD_LATER : ORD_EARLIER;
                        end else if (r_month != r_arg_month) begin
                            n_order = (r_month > r_arg_month) ? ORD_LATER : ORD_EARLIER;
                        end else if (r_day != r_arg_day) begin
                            n_order = (r_day > r_arg_day) ? ORD_LATER : ORD_EARLIER;
                        end else begin
                            n_order = ORD_EQUAL;
                        end
                        n_state = S_DONE;
                    end
                    default: n_state = S_DONE;
                endcase
            end
            S_LOAD: begin
                // Clamp the month into range and the day into the month.
                n_month = load_month;
                n_year  = r_arg_year;
                if (r_arg_day == 5'd0) begin
                    n_day = DAY_FIRST;
                end else if (r_arg_day > load_len) begin
                    n_day = load_len;
                end else begin
                    n_day = r_arg_day;
                end
                n_state = S_DONE;
            end
            S_STEP: begin
                // One day per cycle. The leap flag is registered and lags a year change,
                // but a year changes only into January or December.
                if (r_func == FN_FWD) begin
                    if (r_day >= cur_len) begin
                        n_day = DAY_FIRST;
                        if (r_month >= MONTH_DEC) begin
                            n_month = MONTH_JAN;
                            n_year  = r_year + 16'd1;
                        end else begin
                            n_month = r_month + 4'd1;
                        end
                    end else begin
                        n_day = r_day + 5'd1;
                    end
                end else begin
                    if (r_day <= DAY_FIRST) begin
                        n_month = prev_month;
                        if (r_month <= MONTH_JAN) begin
                            n_year = r_year - 16'd1;
                        end
                        n_day = month_length(prev_month, leap);
                    end else begin
                        n_day = r_day - 5'd1;
                    end
                end
                n_cnt = r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (o_out.ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Channel outputs.
    assign i_in.ready      = (r_state == S_IDLE);
    assign o_out.valid     = (r_state == S_DONE);
    assign o_out.out_day   = r_day;
    assign o_out.out_month = r_month;
    assign o_out.out_year  = r_year;
    assign o_out.order     = r_order;

endmodule

[hdl/cds_checker.sv]
// Port-level checks for the calendar date stepper, bound to its top level.
// Depends on cds_pkg and on the top level's interface ports.
module cds_checker
    import cds_pkg::*;
(
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               i_in_ready,
    input logic               i_out_valid,
    input logic               i_out_ready,
    input logic [DAY_W-1:0]   i_out_day,
    input logic [MONTH_W-1:0] i_out_month,
    input logic [YEAR_W-1:0]  i_out_year,
    input logic [ORDER_W-1:0] i_out_order
);

    // One beat at a time: never ready for input while a result is offered.
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_in_ready && i_out_valid))
        else $error("input ready while a result beat is pending");

    // Accepting a beat closes the input straight after.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> !i_in_ready)
        else $error("input ready straight after an accepted beat");

    // A stalled result beat holds its date.
    a_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_out_year)
            && $stable(i_out_month) && $stable(i_out_day)))
        else $error("stalled result beat changed");

    // A reported date has a month from 1 to 12 and a nonzero day, and the order code is never 3.
    a_date_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_out_month != 4'd0 && i_out_month <= MONTH_DEC
            && i_out_day != 5'd0 && i_out_order != 2'd3))
        else $error("result beat carries an impossible date or order");

    // A taken result reopens the input in the next cycle.
    a_ready_after_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_out_ready) |=> i_in_ready)
        else $error("input not ready after the result beat was taken");

endmodule

bind calendar_date_stepper cds_checker u_cds_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_day   (o_out.out_day),
    .i_out_month (o_out.out_month),
    .i_out_year  (o_out.out_year),
    .i_out_order (o_out.order)
);

[dv/cds_date_checker.sv]
// Checker for the calendar date stepper: watches both channels, predicts each
// result beat from the input beats and compares them field by field.
// Depends on cds_pkg and the channel interfaces in cds_if.
module cds_date_checker import cds_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    cds_in_if    i_in,
    cds_out_if   i_res,
    output int   o_fail_count,
    output int   o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        logic [DAY_W-1:0]   day;
        logic [MONTH_W-1:0] month;
        logic [YEAR_W-1:0]  year;
        t_order             order;
    } t_date_beat;

    // Our own copy of the stored date.
    logic [DAY_W-1:0]   held_day   = DAY_FIRST;
    logic [MONTH_W-1:0] held_month = MONTH_JAN;
    logic [YEAR_W-1:0]  held_year  = '0;

    t_date_beat expected_dates_q[$];
    int         failures        = 0;
    int         results_checked = 0;

    // Gregorian rule: every fourth year, but centuries only when divisible by 400.
    function automatic bit leap_year(input logic [YEAR_W-1:0] y);
        return (y % 4 == 0) && !((y % 100 == 0) && (y % 400 != 0));
    endfunction

    function automatic logic [DAY_W-1:0] days_in_month(input logic [MONTH_W-1:0] m,
                                                        input logic [YEAR_W-1:0]  y);
        case (m)
            4'd4, 4'd6, 4'd9, 4'd11: return 5'd30;
            MONTH_FEB:               return leap_year(y) ? 5'd29 : 5'd28;
            default:                 return 5'd31;
        endcase
    endfunction

    function automatic void step_one_day_ahead();
        if (held_day >= days_in_month(held_month, held_year)) begin
            held_day = DAY_FIRST;
            if (held_month >= MONTH_DEC) begin
                held_month = MONTH_JAN;
                held_year  = held_year + YEAR_W'(1);
            end else begin
                held_month = held_month + MONTH_W'(1);
            end
        end else begin
            held_day = held_day + DAY_W'(1);
        end
    endfunction

    // Going back past the first of a month lands on the last day of the
    // month before, taken in the year that month belongs to.
    function automatic void step_one_day_back();
        if (held_day <= DAY_FIRST) begin
            if (held_month <= MONTH_JAN) begin
                held_month = MONTH_DEC;
                held_year  = held_year - YEAR_W'(1);
            end else begin
                held_month = held_month - MONTH_W'(1);
            end
            held_day = days_in_month(held_month, held_year);
        end else begin
            held_day = held_day - DAY_W'(1);
        end
    endfunction

    // Applies one input beat to the held date and returns the result beat due.
    function automatic t_date_beat predict_date_after(
        input t_func                    fn,
        input logic [COUNT_FIELD_W-1:0] cnt,
        input logic [DAY_W-1:0]         d,
        input logic [MONTH_W-1:0]       m,
        input logic [YEAR_W-1:0]        y
    );
        t_date_beat         res;
        logic [MONTH_W-1:0] mm;
        logic [DAY_W-1:0]   dd;
        logic [DAY_W-1:0]   len;
        int                 steps;
        res.order = ORD_EARLIER;
        steps     = int'(cnt[CNT_W-1:0]);
        case (fn)
            FN_LOAD: begin
                // Out-of-range months and days are clamped, not rejected.
                mm = (m < MONTH_JAN) ? MONTH_JAN : ((m > MONTH_DEC) ? MONTH_DEC : m);
                len = days_in_month(mm, y);
                dd = (d < DAY_FIRST) ? DAY_FIRST : ((d > len) ? len : d);
                held_day   = dd;
                held_month = mm;
                held_year  = y;
            end
            FN_FWD: repeat (steps) step_one_day_ahead();
            FN_BWD: repeat (steps) step_one_day_back();
            FN_CMP: begin
                // Raw fields are compared: year first, then month, then day.
                if (held_year != y)
                    res.order = (held_year > y) ? ORD_LATER : ORD_EARLIER;
                else if (held_month != m)
                    res.order = (held_month > m) ? ORD_LATER : ORD_EARLIER;
                else if (held_day != d)
                    res.order = (held_day > d) ? ORD_LATER : ORD_EARLIER;
                else
                    res.order = ORD_EQUAL;
            end
            default: ;
        endcase
        res.day   = held_day;
        res.month = held_month;
        res.year  = held_year;
        return res;
    endfunction

    // Predict on every accepted input beat, check on every accepted result beat.
    always @(posedge i_clk) begin : track
        t_date_beat want;
        if (!i_rst_n) begin
            held_day   = DAY_FIRST;
            held_month = MONTH_JAN;
            held_year  = '0;
            expected_dates_q.delete();
        end else begin
            if (i_in.valid && i_in.ready)
                expected_dates_q.push_back(predict_date_after(t_func'(i_in.func),
                    i_in.day_count, i_in.in_day, i_in.in_month, i_in.in_year));

            if (i_res.valid && i_res.ready) begin
                if (expected_dates_q.size() == 0) begin
                    failures++;
                    if (failures <= REPORT_LIMIT)
                        $display("result beat %0d with no date outstanding: %0d-%0d-%0d order %0d",
                                 results_checked, i_res.out_year, i_res.out_month,
                                 i_res.out_day, i_res.order);
                end else begin
                    want = expected_dates_q.pop_front();
                    if (want.day !== i_res.out_day || want.month !== i_res.out_month ||
                        want.year !== i_res.out_year || want.order !== i_res.order) begin
                        failures++;
                        if (failures <= REPORT_LIMIT)
                            $display("result beat %0d: expected %0d-%0d-%0d order %0d, got %0d-%0d-%0d order %0d",
                                     results_checked, want.year, want.month, want.day,
                                     want.order, i_res.out_year, i_res.out_month,
                                     i_res.out_day, i_res.order);
                    end
                end
                results_checked++;
            end
        end
        o_fail_count <= failures;
        o_pending    <= expected_dates_q.size();
    end

endmodule

[dv/calendar_date_stepper_tb.sv]
// Top of the date stepper testbench: clock, reset, input beats, result
// back-pressure, watchdog and verdict. Depends on cds_pkg, cds_if, the
// stepper itself and the cds_date_checker module.
module calendar_date_stepper_tb import cds_pkg::*; ();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RESET_CYCLES       = 7;
    localparam int MAX_BURST          = 16;
    localparam int LONG_READY_MAX     = 120;
    localparam int HOLD_OFF_CYCLES    = 300;
    localparam int RANDOM_ITEMS       = 80;
    localparam int CALM_ITEMS         = 20;
    localparam int HOLD_OFF_AT        = 40;
    localparam int LARGE_COUNT_BUDGET = 3;
    localparam int TAIL_CYCLES        = 8;
    // Longest quiet stretch of a good run is a full-length step plus a stall.
    localparam int WATCHDOG_LIMIT =
        4 * ((1 << CNT_W) + 2 + MAX_BURST + HOLD_OFF_CYCLES);

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    cds_in_if  in_ch ();
    cds_out_if res_ch ();

    int fail_count;
    int pending;

    bit calm_phase   = 1'b0;
    bit hold_off_req = 1'b0;
    int steady_left  = 0;
    int large_left   = LARGE_COUNT_BUDGET;
    int idle_cycles  = 0;

    int     beats_sent   = 0;
    int     results_seen = 0;
    int     op_tally[4]  = '{default: 0};
    longint days_stepped = 0;

    // Last date seen on the result channel, used to aim compares.
    logic [DAY_W-1:0]   last_day   = DAY_FIRST;
    logic [MONTH_W-1:0] last_month = MONTH_JAN;
    logic [YEAR_W-1:0]  last_year  = '0;

    always #5 i_clk = ~i_clk;

    calendar_date_stepper u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (res_ch)
    );

    cds_date_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (in_ch),
        .i_res        (res_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // Track the result channel for compare aiming and the summary.
    always @(posedge i_clk) begin
        if (res_ch.valid && res_ch.ready) begin
            last_day     <= res_ch.out_day;
            last_month   <= res_ch.out_month;
            last_year    <= res_ch.out_year;
            results_seen <= results_seen + 1;
        end
    end

    // Watchdog: ends the run when no beat moves on either channel for too long.
    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (res_ch.valid && res_ch.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no beat accepted for %0d cycles", idle_cycles);
            $display("FAILED: results differ");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Optional gap before an input beat, with occasional stretches of none.
    task automatic pace_input();
        if (calm_phase) begin
        end else if (steady_left > 0) begin
            steady_left--;
        end else if ($urandom_range(0, 7) == 0) begin
            steady_left = $urandom_range(5, 15);
        end else if ($urandom_range(0, 2) == 0) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, MAX_BURST)) @(posedge i_clk);
        end
    endtask

    // Offers one input beat and returns at the edge where it is accepted.
    task automatic send_beat(input t_func                    fn,
                             input logic [COUNT_FIELD_W-1:0] cnt,
                             input logic [DAY_W-1:0]         d,
                             input logic [MONTH_W-1:0]       m,
                             input logic [YEAR_W-1:0]        y);
        pace_input();
        in_ch.valid     <= 1'b1;
        in_ch.func      <= fn;
        in_ch.day_count <= cnt;
        in_ch.in_day    <= d;
        in_ch.in_month  <= m;
        in_ch.in_year   <= y;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        beats_sent++;
        op_tally[fn]++;
        if (fn == FN_FWD || fn == FN_BWD)
            days_stepped += cnt;
    endtask

    // Mostly short steps; a handful of long ones and at most a few full-range.
    function automatic logic [COUNT_FIELD_W-1:0] pick_count();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 3 && large_left > 0) begin
            large_left--;
            return COUNT_FIELD_W'($urandom);
        end else if (sel < 10) begin
            return COUNT_FIELD_W'($urandom_range(1201, 5000));
        end else if (sel < 30) begin
            return COUNT_FIELD_W'($urandom_range(41, 1200));
        end
        return COUNT_FIELD_W'($urandom_range(0, 40));
    endfunction

    // Years around centuries, around the wrap point, or anywhere.
    function automatic logic [YEAR_W-1:0] pick_year();
        int base;
        case ($urandom_range(0, 3))
            0: begin
                base = 400 * $urandom_range(4, 6) + 100 * $urandom_range(0, 3);
                return YEAR_W'(base + $urandom_range(0, 8) - 4);
            end
            1: return ($urandom_range(0, 1) != 0) ? YEAR_W'(65535 - $urandom_range(0, 3))
                                                  : YEAR_W'($urandom_range(0, 3));
            default: return YEAR_W'($urandom);
        endcase
    endfunction

    task automatic issue_random_item();
        int                 sel;
        logic [DAY_W-1:0]   d;
        logic [MONTH_W-1:0] m;
        logic [YEAR_W-1:0]  y;
        sel = $urandom_range(0, 99);
        d   = DAY_W'($urandom);
        m   = MONTH_W'($urandom);
        y   = YEAR_W'($urandom);
        if (sel < 20) begin
            // Most loads are plausible dates; the rest keep raw noise.
            if ($urandom_range(0, 4) != 0) begin
                d = DAY_W'($urandom_range(1, 31));
                m = MONTH_W'($urandom_range(1, 12));
                y = pick_year();
            end
            send_beat(FN_LOAD, COUNT_FIELD_W'($urandom), d, m, y);
        end else if (sel < 50) begin
            send_beat(FN_FWD, pick_count(), d, m, y);
        end else if (sel < 80) begin
            send_beat(FN_BWD, pick_count(), d, m, y);
        end else begin
            if ($urandom_range(0, 4) < 3) begin
                // Aim close to the stored date: drain first so it is known.
                in_ch.valid <= 1'b0;
                @(posedge i_clk);
                while (results_seen != beats_sent) @(posedge i_clk);
                d = last_day;
                m = last_month;
                y = last_year;
                case ($urandom_range(0, 7))
                    2: d = d + DAY_W'(1);
                    3: d = d - DAY_W'(1);
                    4: m = m + MONTH_W'(1);
                    5: m = m - MONTH_W'(1);
                    6: y = y + YEAR_W'(1);
                    7: y = y - YEAR_W'(1);
                    default: ;
                endcase
            end
            send_beat(FN_CMP, COUNT_FIELD_W'($urandom), d, m, y);
        end
    endtask

    // Result side: random ready bursts, one long hold-off, steady at the end.
    initial begin : result_sink
        int   burst;
        logic take;
        res_ch.ready = 1'b0;
        forever begin
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                repeat (HOLD_OFF_CYCLES) begin
                    @(posedge i_clk);
                    res_ch.ready <= 1'b0;
                end
            end else if (calm_phase) begin
                @(posedge i_clk);
                res_ch.ready <= 1'b1;
            end else begin
                if ($urandom_range(0, 7) == 0) begin
                    burst = $urandom_range(30, LONG_READY_MAX);
                    take  = 1'b1;
                end else begin
                    burst = $urandom_range(1, MAX_BURST);
                    take  = ($urandom_range(0, 2) != 0);
                end
                repeat (burst) begin
                    @(posedge i_clk);
                    res_ch.ready <= take;
                end
            end
        end
    end

    // Input side: reset, directed beats, random beats, drain and verdict.
    initial begin : stimulus
        int n;
        in_ch.valid     = 1'b0;
        in_ch.func      = FN_LOAD;
        in_ch.day_count = '0;
        in_ch.in_day    = '0;
        in_ch.in_month  = '0;
        in_ch.in_year   = '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Zero day and month clamp to the first of January; wrap both ways.
        send_beat(FN_LOAD, 16'h0000, 5'd0, 4'd0, 16'd0);
        send_beat(FN_CMP, 16'h0000, 5'd0, 4'd0, 16'd0);
        send_beat(FN_BWD, 16'd1, 5'd0, 4'd0, 16'd0);
        send_beat(FN_FWD, 16'd1, 5'd31, 4'd15, 16'hFFFF);

        // Month above twelve clamps to December; compare against raw fields.
        send_beat(FN_LOAD, 16'hFFFF, 5'd31, 4'd15, 16'hFFFF);
        send_beat(FN_CMP, 16'd0, 5'd31, 4'd15, 16'hFFFF);
        send_beat(FN_CMP, 16'd0, 5'd31, MONTH_DEC, 16'hFFFF);
        send_beat(FN_FWD, 16'd0, 5'd31, 4'd15, 16'hFFFF);
        send_beat(FN_BWD, 16'd0, 5'd0, 4'd0, 16'd0);

        // Day clamps to the February length under each leap rule.
        send_beat(FN_LOAD, 16'd0, 5'd31, MONTH_FEB, 16'd2000);
        send_beat(FN_FWD, 16'd1, 5'd0, 4'd0, 16'd0);
        send_beat(FN_BWD, 16'd1, 5'd0, 4'd0, 16'd0);
        send_beat(FN_LOAD, 16'd0, 5'd30, MONTH_FEB, 16'd1900);
        send_beat(FN_LOAD, 16'd0, 5'd31, MONTH_FEB, 16'd2004);
        send_beat(FN_LOAD, 16'd0, 5'd31, MONTH_FEB, 16'd2001);

        // Stepping back from the first takes the previous month's length.
        send_beat(FN_LOAD, 16'd0, DAY_FIRST, 4'd3, 16'd1900);
        send_beat(FN_BWD, 16'd1, 5'd0, 4'd0, 16'd0);
        send_beat(FN_LOAD, 16'd0, 5'd31, 4'd4, 16'd2023);
        send_beat(FN_LOAD, 16'd0, DAY_FIRST, 4'd5, 16'd2024);
        send_beat(FN_BWD, 16'd1, 5'd0, 4'd0, 16'd0);

        // A compare decided by the year, one by the day and one by the month.
        send_beat(FN_CMP, 16'd0, 5'd30, 4'd4, 16'd2025);
        send_beat(FN_CMP, 16'd0, 5'd29, 4'd4, 16'd2024);
        send_beat(FN_CMP, 16'd0, DAY_FIRST, 4'd5, 16'd2024);

        // Full-range steps there and back.
        send_beat(FN_FWD, 16'hFFFF, 5'd0, 4'd0, 16'd0);
        send_beat(FN_BWD, 16'hFFFF, 5'd0, 4'd0, 16'd0);

        for (n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == RANDOM_ITEMS - CALM_ITEMS)
                calm_phase = 1'b1;
            if (n == HOLD_OFF_AT)
                hold_off_req = 1'b1;
            issue_random_item();
        end
        in_ch.valid <= 1'b0;

        // The pending count shows the last beat only from the next edge on.
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Run covered %0d loads, %0d forward, %0d backward and %0d compare beats.",
                 op_tally[FN_LOAD], op_tally[FN_FWD], op_tally[FN_BWD], op_tally[FN_CMP]);
        $display("%0d days stepped in all, %0d result beats checked, one %0d-cycle stall.",
                 days_stepped, results_seen, HOLD_OFF_CYCLES);
        if (fail_count == 0 && pending == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
